>>> sv/thumb_instruction_decoder_macros.svh
// Assertion macros shared by the decoder's checker.
`ifndef THUMB_INSTRUCTION_DECODER_MACROS_SVH
`define THUMB_INSTRUCTION_DECODER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TID_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TID_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/tid_pkg.sv
// Shared types and constants of the Thumb instruction decoder.
package tid_pkg;

	localparam int unsigned ADDR_WIDTH_DEF = 32;
	localparam int unsigned PC_AHEAD       = 4;
	localparam logic [31:0] ALIGN_WORD     = 32'hFFFF_FFFC;

	// Match patterns on the top bits of the halfword
	localparam logic [4:0] OP_UNCOND_B  = 5'b11100;
	localparam logic [3:0] OP_COND_B    = 4'b1101;
	localparam logic [7:0] OP_HI_MOV    = 8'b01000110;
	localparam logic [5:0] OP_ALU       = 6'b010000;
	localparam logic [6:0] OP_POP       = 7'b1011110;

	typedef enum logic [5:0] {
		CLS_NONE      = 6'd0,
		CLS_SHIFT     = 6'd1,
		CLS_ADD_REG   = 6'd2,
		CLS_SUB_REG   = 6'd3,
		CLS_MOV_LOW   = 6'd4,
		CLS_ADD_IMM3  = 6'd5,
		CLS_SUB_IMM3  = 6'd6,
		CLS_MOV_IMM8  = 6'd7,
		CLS_CMP_IMM8  = 6'd8,
		CLS_ADD_IMM8  = 6'd9,
		CLS_SUB_IMM8  = 6'd10,
		CLS_ALU       = 6'd11,
		CLS_ADD_HI    = 6'd12,
		CLS_CMP_HI    = 6'd13,
		CLS_MOV_HI    = 6'd14,
		CLS_NOP       = 6'd15,
		CLS_BX        = 6'd16,
		CLS_RET       = 6'd17,
		CLS_BLX_REG   = 6'd18,
		CLS_LDST_REG  = 6'd19,
		CLS_LDST_IMM  = 6'd20,
		CLS_LDST_SP   = 6'd21,
		CLS_LDR_PC    = 6'd22,
		CLS_ADD_SP    = 6'd23,
		CLS_SUB_SP    = 6'd24,
		CLS_ADR_PC    = 6'd25,
		CLS_ADR_SP    = 6'd26,
		CLS_B_COND    = 6'd27,
		CLS_SXTB      = 6'd28,
		CLS_SXTH      = 6'd29,
		CLS_PUSH_POP  = 6'd30,
		CLS_LDM_STM   = 6'd31,
		CLS_B         = 6'd32,
		CLS_BL        = 6'd33,
		CLS_BLX       = 6'd34
	} tid_class_t;

	localparam logic [3:0] REG_SP = 4'd13;
	localparam logic [3:0] REG_LR = 4'd14;
	localparam logic [3:0] REG_PC = 4'd15;
	localparam logic [3:0] REG_R8 = 4'd8;

	typedef struct packed {
		logic [5:0]  instr_class;
		logic [3:0]  variant;
		logic [3:0]  dest_reg;
		logic [3:0]  base_reg;
		logic [3:0]  index_reg;
		logic [9:0]  immediate;
		logic [3:0]  condition;
		logic [7:0]  reg_list;
		logic        extra_reg;
		logic [22:0] branch_offset;
		logic [31:0] target;
		logic        decoded;
	} tid_result_t;

endpackage

>>> sv/tid_decode.sv
// Combinational classify-and-extract logic for one Thumb halfword.
module tid_decode import tid_pkg::*; #(
	parameter int unsigned ADDR_WIDTH = ADDR_WIDTH_DEF
) (
	input  logic [15:0]           halfword,
	input  logic [ADDR_WIDTH-1:0] address,
	input  logic                  pending,
	input  logic [10:0]           held_prefix,
	input  logic [ADDR_WIDTH-1:0] held_address,
	output logic                  is_prefix,
	output tid_result_t           result
);

	typedef enum logic [1:0] {
		TK_NONE,
		TK_LIT,
		TK_REL,
		TK_LONG
	} tgt_kind_t;

	tid_class_t cls;
	tgt_kind_t  kind;
	logic       align;
	logic [3:0] var_c, rd, rb, ri, cond;
	logic [9:0] imm;
	logic [7:0] list;
	logic       xr;
	logic [22:0] off;

	logic [2:0] lo3, mid3, hi3, r8;
	logic [7:0] imm8;
	logic [4:0] i5, f5;

	logic [ADDR_WIDTH+22:0] off_wide;
	logic [ADDR_WIDTH-1:0]  pc, tgt_base, tgt_add, tgt_sum;

	assign lo3  = halfword[2:0];
	assign mid3 = halfword[5:3];
	assign hi3  = halfword[8:6];
	assign r8   = halfword[10:8];
	assign imm8 = halfword[7:0];
	assign i5   = halfword[10:6];
	assign f5   = halfword[15:11];

	always_comb begin
		cls = CLS_NONE; kind = TK_NONE; align = 1'b0; is_prefix = 1'b0;
		var_c = '0; rd = '0; rb = '0; ri = '0; cond = '0;
		imm = '0; list = '0; xr = 1'b0; off = '0;
		priority if (pending) begin
			// second half of a long branch: offset fields just concatenate
			off  = {held_prefix, halfword[10:0], 1'b0};
			kind = TK_LONG;
			if (halfword[12:11] == 2'b01) begin
				cls = CLS_BLX; align = 1'b1;
			end else begin
				cls = CLS_BL;
			end
		end else if (halfword[15:13] == 3'b111 && f5 != OP_UNCOND_B) begin
			is_prefix = 1'b1;
		end else if (f5 <= 5'd2) begin
			cls = CLS_SHIFT; var_c = {2'b00, f5[1:0]}; imm = {5'b0, i5};
			rb = {1'b0, mid3}; rd = {1'b0, lo3};
		end else if (halfword[15:10] == 6'b000110) begin
			cls = halfword[9] ? CLS_SUB_REG : CLS_ADD_REG;
			rd = {1'b0, lo3}; rb = {1'b0, mid3}; ri = {1'b0, hi3};
		end else if (halfword[15:9] == 7'b0001110 && hi3 == 3'd0) begin
			cls = CLS_MOV_LOW; rd = {1'b0, lo3}; rb = {1'b0, mid3};
		end else if (halfword[15:10] == 6'b000111) begin
			cls = halfword[9] ? CLS_SUB_IMM3 : CLS_ADD_IMM3;
			rd = {1'b0, lo3}; rb = {1'b0, mid3}; imm = {7'b0, hi3};
		end else if (halfword[15:13] == 3'b001) begin
			cls = tid_class_t'(6'(CLS_MOV_IMM8) + {4'b0, halfword[12:11]});
			rd = {1'b0, r8}; imm = {2'b0, imm8};
		end else if (halfword[15:10] == OP_ALU) begin
			cls = CLS_ALU; var_c = halfword[9:6]; rd = {1'b0, lo3}; rb = {1'b0, mid3};
		end else if (halfword[15:10] == 6'b010001 && halfword[9:8] != 2'b11) begin
			rd = {halfword[7], lo3};
			rb = halfword[6:3];
			unique case (halfword[9:8])
				2'b00:   cls = CLS_ADD_HI;
				2'b01:   cls = CLS_CMP_HI;
				default: cls = (rd == REG_R8 && rb == REG_R8) ? CLS_NOP : CLS_MOV_HI;
			endcase
		end else if (halfword[15:7] == {OP_HI_MOV[7:1], 2'b10}) begin
			rb  = halfword[6:3];
			cls = (rb == REG_LR) ? CLS_RET : CLS_BX;
		end else if (halfword[15:7] == {OP_HI_MOV[7:1], 2'b11}) begin
			cls = CLS_BLX_REG; rb = halfword[6:3];
		end else if (halfword[15:12] == 4'b0101) begin
			cls = CLS_LDST_REG; var_c = {1'b0, halfword[11:9]};
			rd = {1'b0, lo3}; rb = {1'b0, mid3}; ri = {1'b0, hi3};
		end else if (f5 >= 5'd12 && f5 <= 5'd17) begin
			cls = CLS_LDST_IMM; rd = {1'b0, lo3}; rb = {1'b0, mid3};
			if (f5 <= 5'd13) begin
				var_c = {3'b000, f5[0]}; imm = {3'b0, i5, 2'b00};
			end else if (f5 <= 5'd15) begin
				var_c = {3'b001, f5[0]}; imm = {5'b0, i5};
			end else begin
				var_c = {3'b010, f5[0]}; imm = {4'b0, i5, 1'b0};
			end
		end else if (halfword[15:12] == 4'b1001) begin
			cls = CLS_LDST_SP; var_c = {3'b0, halfword[11]};
			rd = {1'b0, r8}; rb = REG_SP; imm = {imm8, 2'b00};
		end else if (f5 == 5'b01001) begin
			cls = CLS_LDR_PC; rd = {1'b0, r8}; rb = REG_PC; imm = {imm8, 2'b00};
			kind = TK_LIT;
		end else if (halfword[15:8] == 8'hB0) begin
			cls = halfword[7] ? CLS_SUB_SP : CLS_ADD_SP;
			rd = REG_SP; imm = {1'b0, halfword[6:0], 2'b00};
		end else if (f5 == 5'b10100) begin
			cls = CLS_ADR_PC; rd = {1'b0, r8}; rb = REG_PC; imm = {imm8, 2'b00};
			kind = TK_LIT;
		end else if (f5 == 5'b10101) begin
			cls = CLS_ADR_SP; rd = {1'b0, r8}; rb = REG_SP; imm = {imm8, 2'b00};
		end else if (halfword[15:12] == OP_COND_B && halfword[11:9] != 3'b111) begin
			cls = CLS_B_COND; cond = halfword[11:8];
			off = {{14{imm8[7]}}, imm8, 1'b0}; kind = TK_REL;
		end else if (halfword[15:7] == 9'b101100100) begin
			cls = halfword[6] ? CLS_SXTB : CLS_SXTH;
			rd = {1'b0, lo3}; rb = {1'b0, mid3};
		end else if (halfword[15:12] == OP_POP[6:3] && halfword[10:9] == OP_POP[1:0]) begin
			cls = CLS_PUSH_POP; var_c = {3'b0, halfword[11]}; rb = REG_SP;
			list = imm8; xr = halfword[8];
		end else if (halfword[15:12] == 4'b1100) begin
			cls = CLS_LDM_STM; var_c = {3'b0, halfword[11]}; rb = {1'b0, r8}; list = imm8;
		end else if (f5 == OP_UNCOND_B) begin
			cls = CLS_B; off = {{11{halfword[10]}}, halfword[10:0], 1'b0}; kind = TK_REL;
		end else begin
			cls = CLS_NONE;
		end
	end

	// One adder serves every target form
	assign off_wide = {{ADDR_WIDTH{off[22]}}, off};
	assign pc       = address + ADDR_WIDTH'(PC_AHEAD);

	always_comb begin
		unique case (kind)
			TK_LIT: begin
				tgt_base = pc & ALIGN_WORD[ADDR_WIDTH-1:0];
				tgt_add  = {{(ADDR_WIDTH-10){1'b0}}, imm};
			end
			TK_REL: begin
				tgt_base = pc;
				tgt_add  = off_wide[ADDR_WIDTH-1:0];
			end
			TK_LONG: begin
				tgt_base = held_address + ADDR_WIDTH'(PC_AHEAD);
				tgt_add  = off_wide[ADDR_WIDTH-1:0];
			end
			default: begin
				tgt_base = '0;
				tgt_add  = '0;
			end
		endcase
	end

	assign tgt_sum = align ? ((tgt_base + tgt_add) & ALIGN_WORD[ADDR_WIDTH-1:0])
		: (tgt_base + tgt_add);

	always_comb begin
		result               = '0;
		result.instr_class   = cls;
		result.variant       = var_c;
		result.dest_reg      = rd;
		result.base_reg      = rb;
		result.index_reg     = ri;
		result.immediate     = imm;
		result.condition     = cond;
		result.reg_list      = list;
		result.extra_reg     = xr;
		result.branch_offset = off;
		result.target        = 32'(tgt_sum);
		result.decoded       = (cls != CLS_NONE);
	end

endmodule

>>> sv/thumb_instruction_decoder.sv
// Top level of the Thumb instruction decoder: input stage, prefix hold, result register.
//
// Decodes one 16-bit Thumb halfword per beat into its class, register numbers,
// op/kind, scaled immediate, condition, register list and PC-relative target
// (PC = address + 4). A beat is first captured in the input register; the
// decode logic between that register and the result register is a single
// pass, so a beat's result is registered when the input stage advances, and
// a new halfword is accepted every cycle while out_ready stays high. The
// sustained rate is one halfword per cycle, limited only by the single
// result register draining through out_ready. The first half of a long
// branch (top bits 111 but not 11100) produces no result beat: the decoder
// holds its offset bits and address, and the next halfword, whatever it is,
// completes a BL, or a BLX with the target aligned down to a word when its
// bits 12..11 are 01. Unmatched halfwords give class 0 with every field 0.
// Only the low ADDR_WIDTH bits of the address take part in target math, and
// targets wrap modulo 2^ADDR_WIDTH.
module thumb_instruction_decoder import tid_pkg::*; #(
	parameter int unsigned ADDR_WIDTH = ADDR_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] halfword,
	input  logic [31:0] address,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  instr_class,
	output logic [3:0]  variant,
	output logic [3:0]  dest_reg,
	output logic [3:0]  base_reg,
	output logic [3:0]  index_reg,
	output logic [9:0]  immediate,
	output logic [3:0]  condition,
	output logic [7:0]  reg_list,
	output logic        extra_reg,
	output logic [22:0] branch_offset,
	output logic [31:0] target,
	output logic        decoded
);

	// input stage
	logic                  valid_s1;
	logic [15:0]           hw_s1;
	logic [ADDR_WIDTH-1:0] addr_s1;

	// long-branch prefix hold
	logic                  pending_q;
	logic [10:0]           held_prefix_q;
	logic [ADDR_WIDTH-1:0] held_addr_q;

	// result register
	logic                  out_valid_q;
	tid_result_t           res_q;

	logic                  is_prefix;
	tid_result_t           res_d;
	logic                  adv_s1;

	tid_decode #(
		.ADDR_WIDTH(ADDR_WIDTH)
	) u_decode (
		.halfword    (hw_s1),
		.address     (addr_s1),
		.pending     (pending_q),
		.held_prefix (held_prefix_q),
		.held_address(held_addr_q),
		.is_prefix   (is_prefix),
		.result      (res_d)
	);

	// Advance the input stage when its beat is a prefix (no result to place)
	// or the result register is free or draining this cycle.
	assign adv_s1   = valid_s1 && (is_prefix || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			pending_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1    <= (in_valid && in_ready) || (valid_s1 && !adv_s1);
			// a consumed beat either sets the hold (prefix) or clears it
			if (adv_s1) begin
				pending_q <= is_prefix;
			end
			out_valid_q <= (adv_s1 && !is_prefix) || (out_valid_q && !out_ready);
		end
	end

	// Payload registers: input loads on handshake, hold and result on advance.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			hw_s1   <= halfword;
			addr_s1 <= address[ADDR_WIDTH-1:0];
		end
		if (adv_s1 && is_prefix) begin
			held_prefix_q <= hw_s1[10:0];
			held_addr_q   <= addr_s1;
		end
		if (adv_s1 && !is_prefix) begin
			res_q <= res_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign instr_class   = res_q.instr_class;
	assign variant       = res_q.variant;
	assign dest_reg      = res_q.dest_reg;
	assign base_reg      = res_q.base_reg;
	assign index_reg     = res_q.index_reg;
	assign immediate     = res_q.immediate;
	assign condition     = res_q.condition;
	assign reg_list      = res_q.reg_list;
	assign extra_reg     = res_q.extra_reg;
	assign branch_offset = res_q.branch_offset;
	assign target        = res_q.target;
	assign decoded       = res_q.decoded;

endmodule

>>> sv/tid_checker.sv
// Port-level checker for the Thumb instruction decoder and its bind.
`include "thumb_instruction_decoder_macros.svh"

module tid_checker import tid_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [15:0] halfword,
	input logic [31:0] address,
	input logic        out_valid,
	input logic        out_ready,
	input logic [5:0]  instr_class,
	input logic [3:0]  variant,
	input logic [3:0]  dest_reg,
	input logic [3:0]  base_reg,
	input logic [3:0]  index_reg,
	input logic [9:0]  immediate,
	input logic [3:0]  condition,
	input logic [7:0]  reg_list,
	input logic        extra_reg,
	input logic [22:0] branch_offset,
	input logic [31:0] target,
	input logic        decoded
);

	`TID_ASSERT_NOW(a_decoded_flag, out_valid, decoded == (instr_class != CLS_NONE), "decoded flag disagrees with class")

	`TID_ASSERT_NOW(a_unmatched_zero, out_valid && !decoded, variant == 4'd0 && dest_reg == 4'd0 && base_reg == 4'd0 && index_reg == 4'd0 && immediate == 10'd0 && condition == 4'd0 && reg_list == 8'd0 && !extra_reg && branch_offset == 23'd0 && target == 32'd0, "unmatched halfword has a nonzero field")

	`TID_ASSERT_NOW(a_blx_aligned, out_valid && instr_class == CLS_BLX, target[1:0] == 2'b00, "blx target not word aligned")

	`TID_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(instr_class) && $stable(target), "stalled result beat changed")

endmodule

bind thumb_instruction_decoder tid_checker u_tid_checker (.*);

>>> verif/thumb_decode_checker.sv
// Checker for the Thumb decoder: predicts each result beat and compares it with the output port.
`timescale 1ns / 100ps

module thumb_decode_checker import tid_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [15:0] halfword,
	input  logic [31:0] address,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [5:0]  instr_class,
	input  logic [3:0]  variant,
	input  logic [3:0]  dest_reg,
	input  logic [3:0]  base_reg,
	input  logic [3:0]  index_reg,
	input  logic [9:0]  immediate,
	input  logic [3:0]  condition,
	input  logic [7:0]  reg_list,
	input  logic        extra_reg,
	input  logic [22:0] branch_offset,
	input  logic [31:0] target,
	input  logic        decoded,
	output int          mismatches,
	output int          awaiting
);

	// Opcode patterns on the top bits of the halfword
	localparam logic [2:0] TOP_SHIFT     = 3'b000;
	localparam logic [2:0] TOP_IMM8      = 3'b001;
	localparam logic [2:0] TOP_LONG      = 3'b111;
	localparam logic [1:0] SHIFT_NONE    = 2'b11;
	localparam logic [6:0] F7_ADD_REG    = 7'h0C;
	localparam logic [6:0] F7_SUB_REG    = 7'h0D;
	localparam logic [6:0] F7_ADD_IMM3   = 7'h0E;
	localparam logic [6:0] F7_SUB_IMM3   = 7'h0F;
	localparam logic [7:0] F8_ADD_HI     = 8'h44;
	localparam logic [7:0] F8_CMP_HI     = 8'h45;
	localparam logic [8:0] F9_BX         = 9'h08E;
	localparam logic [8:0] F9_BLX        = 9'h08F;
	localparam logic [3:0] NIB_LDST_REG  = 4'h5;
	localparam logic [3:0] NIB_LDST_WORD = 4'h6;
	localparam logic [3:0] NIB_LDST_BYTE = 4'h7;
	localparam logic [3:0] NIB_LDST_HALF = 4'h8;
	localparam logic [3:0] NIB_LDST_SP   = 4'h9;
	localparam logic [4:0] F5_LDR_PC     = 5'd9;
	localparam logic [8:0] F9_ADD_SP     = 9'h160;
	localparam logic [8:0] F9_SUB_SP     = 9'h161;
	localparam logic [4:0] F5_ADR_PC     = 5'd20;
	localparam logic [4:0] F5_ADR_SP     = 5'd21;
	localparam logic [3:0] COND_UNDEF    = 4'hE;
	localparam logic [9:0] F10_SXTB      = 10'h2C9;
	localparam logic [9:0] F10_SXTH      = 10'h2C8;
	localparam logic [6:0] F7_PUSH       = 7'h5A;
	localparam logic [3:0] NIB_LDM_STM   = 4'hC;
	localparam logic [1:0] SUFFIX_BLX    = 2'b01;

	tid_result_t decode_q[$];
	logic        prefix_held;
	logic [15:0] prefix_hw;
	logic [31:0] prefix_addr;
	int          fail_count;

	assign mismatches = fail_count;

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		fail_count++;
		$display("%0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	// Decode one accepted halfword; returns 0 when it is a held long-branch prefix.
	function automatic bit decode_halfword(input logic [15:0] hw, input logic [31:0] addr,
			output tid_result_t r);
		logic [31:0] pc;
		logic [31:0] off;
		logic [31:0] tgt;
		logic [4:0]  f5;
		logic [6:0]  f7;
		logic [7:0]  f8;
		logic [8:0]  f9;
		logic [9:0]  f10;
		pc  = addr + 32'd4;
		off = '0;
		tgt = '0;
		r   = '0;
		f5  = hw[15:11];
		f7  = hw[15:9];
		f8  = hw[15:8];
		f9  = hw[15:7];
		f10 = hw[15:6];
		if (prefix_held) begin
			// Whatever follows a prefix completes it
			prefix_held = 1'b0;
			off = {{9{prefix_hw[10]}}, prefix_hw[10:0], 12'd0} + {20'd0, hw[10:0], 1'b0};
			tgt = prefix_addr + 32'd4 + off;
			if (hw[12:11] == SUFFIX_BLX) begin
				r.instr_class = CLS_BLX;
				tgt = tgt & ALIGN_WORD;
			end else begin
				r.instr_class = CLS_BL;
			end
		end else if (hw[15:13] == TOP_LONG && f5 != OP_UNCOND_B) begin
			prefix_held = 1'b1;
			prefix_hw   = hw;
			prefix_addr = addr;
			return 1'b0;
		end else if (hw[15:13] == TOP_SHIFT && hw[12:11] != SHIFT_NONE) begin
			r.instr_class = CLS_SHIFT;
			r.variant     = {2'b00, hw[12:11]};
			r.immediate   = {5'd0, hw[10:6]};
			r.base_reg    = {1'b0, hw[5:3]};
			r.dest_reg    = {1'b0, hw[2:0]};
		end else if (f7 == F7_ADD_REG || f7 == F7_SUB_REG) begin
			r.instr_class = (f7 == F7_ADD_REG) ? CLS_ADD_REG : CLS_SUB_REG;
			r.dest_reg    = {1'b0, hw[2:0]};
			r.base_reg    = {1'b0, hw[5:3]};
			r.index_reg   = {1'b0, hw[8:6]};
		end else if (f7 == F7_ADD_IMM3 && hw[8:6] == 3'd0) begin
			r.instr_class = CLS_MOV_LOW;
			r.dest_reg    = {1'b0, hw[2:0]};
			r.base_reg    = {1'b0, hw[5:3]};
		end else if (f7 == F7_ADD_IMM3 || f7 == F7_SUB_IMM3) begin
			r.instr_class = (f7 == F7_ADD_IMM3) ? CLS_ADD_IMM3 : CLS_SUB_IMM3;
			r.dest_reg    = {1'b0, hw[2:0]};
			r.base_reg    = {1'b0, hw[5:3]};
			r.immediate   = {7'd0, hw[8:6]};
		end else if (hw[15:13] == TOP_IMM8) begin
			r.instr_class = CLS_MOV_IMM8 + 6'(hw[12:11]);
			r.dest_reg    = {1'b0, hw[10:8]};
			r.immediate   = {2'd0, hw[7:0]};
		end else if (hw[15:10] == OP_ALU) begin
			r.instr_class = CLS_ALU;
			r.variant     = hw[9:6];
			r.dest_reg    = {1'b0, hw[2:0]};
			r.base_reg    = {1'b0, hw[5:3]};
		end else if (f8 == F8_ADD_HI || f8 == F8_CMP_HI || f8 == OP_HI_MOV) begin
			r.instr_class = CLS_ADD_HI + 6'(f8[1:0]);
			r.dest_reg    = {hw[7], hw[2:0]};
			r.base_reg    = hw[6:3];
			if (f8 == OP_HI_MOV && r.dest_reg == REG_R8 && r.base_reg == REG_R8)
				r.instr_class = CLS_NOP;
		end else if (f9 == F9_BX) begin
			r.base_reg    = hw[6:3];
			r.instr_class = (hw[6:3] == REG_LR) ? CLS_RET : CLS_BX;
		end else if (f9 == F9_BLX) begin
			r.instr_class = CLS_BLX_REG;
			r.base_reg    = hw[6:3];
		end else if (hw[15:12] == NIB_LDST_REG) begin
			r.instr_class = CLS_LDST_REG;
			r.variant     = {1'b0, hw[11:9]};
			r.dest_reg    = {1'b0, hw[2:0]};
			r.base_reg    = {1'b0, hw[5:3]};
			r.index_reg   = {1'b0, hw[8:6]};
		end else if (hw[15:12] == NIB_LDST_WORD || hw[15:12] == NIB_LDST_BYTE ||
				hw[15:12] == NIB_LDST_HALF) begin
			r.instr_class = CLS_LDST_IMM;
			r.dest_reg    = {1'b0, hw[2:0]};
			r.base_reg    = {1'b0, hw[5:3]};
			// variant is size*2 + load, immediate is scaled by the access size
			if (hw[15:12] == NIB_LDST_WORD) begin
				r.variant   = {3'd0, hw[11]};
				r.immediate = {3'd0, hw[10:6], 2'd0};
			end else if (hw[15:12] == NIB_LDST_BYTE) begin
				r.variant   = {3'd1, hw[11]};
				r.immediate = {5'd0, hw[10:6]};
			end else begin
				r.variant   = {3'd2, hw[11]};
				r.immediate = {4'd0, hw[10:6], 1'b0};
			end
		end else if (hw[15:12] == NIB_LDST_SP) begin
			r.instr_class = CLS_LDST_SP;
			r.variant     = {3'd0, hw[11]};
			r.dest_reg    = {1'b0, hw[10:8]};
			r.base_reg    = REG_SP;
			r.immediate   = {hw[7:0], 2'd0};
		end else if (f5 == F5_LDR_PC) begin
			r.instr_class = CLS_LDR_PC;
			r.dest_reg    = {1'b0, hw[10:8]};
			r.base_reg    = REG_PC;
			r.immediate   = {hw[7:0], 2'd0};
			tgt = (pc & ALIGN_WORD) + {22'd0, r.immediate};
		end else if (f9 == F9_ADD_SP || f9 == F9_SUB_SP) begin
			r.instr_class = (f9 == F9_ADD_SP) ? CLS_ADD_SP : CLS_SUB_SP;
			r.dest_reg    = REG_SP;
			r.immediate   = {1'b0, hw[6:0], 2'd0};
		end else if (f5 == F5_ADR_PC) begin
			r.instr_class = CLS_ADR_PC;
			r.dest_reg    = {1'b0, hw[10:8]};
			r.base_reg    = REG_PC;
			r.immediate   = {hw[7:0], 2'd0};
			tgt = (pc & ALIGN_WORD) + {22'd0, r.immediate};
		end else if (f5 == F5_ADR_SP) begin
			r.instr_class = CLS_ADR_SP;
			r.dest_reg    = {1'b0, hw[10:8]};
			r.base_reg    = REG_SP;
			r.immediate   = {hw[7:0], 2'd0};
		end else if (hw[15:12] == OP_COND_B && hw[11:8] < COND_UNDEF) begin
			r.instr_class = CLS_B_COND;
			r.condition   = hw[11:8];
			off = {{23{hw[7]}}, hw[7:0], 1'b0};
			tgt = pc + off;
		end else if (f10 == F10_SXTB || f10 == F10_SXTH) begin
			r.instr_class = (f10 == F10_SXTB) ? CLS_SXTB : CLS_SXTH;
			r.dest_reg    = {1'b0, hw[2:0]};
			r.base_reg    = {1'b0, hw[5:3]};
		end else if (f7 == F7_PUSH || f7 == OP_POP) begin
			r.instr_class = CLS_PUSH_POP;
			r.variant     = (f7 == OP_POP) ? 4'd1 : 4'd0;
			r.base_reg    = REG_SP;
			r.reg_list    = hw[7:0];
			r.extra_reg   = hw[8];
		end else if (hw[15:12] == NIB_LDM_STM) begin
			r.instr_class = CLS_LDM_STM;
			r.variant     = {3'd0, hw[11]};
			r.base_reg    = {1'b0, hw[10:8]};
			r.reg_list    = hw[7:0];
		end else if (f5 == OP_UNCOND_B) begin
			r.instr_class = CLS_B;
			off = {{20{hw[10]}}, hw[10:0], 1'b0};
			tgt = pc + off;
		end
		r.branch_offset = off[22:0];
		r.target        = tgt;
		r.decoded       = (r.instr_class != CLS_NONE);
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tid_result_t want;
		tid_result_t fresh;
		if (!arst_n) begin
			prefix_held = 1'b0;
			prefix_hw   = '0;
			prefix_addr = '0;
			fail_count  = 0;
			decode_q.delete();
			awaiting <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (decode_q.size() == 0) begin
					flag_mismatch("result beat with nothing expected, class", 32'(instr_class),
						32'(CLS_NONE));
				end else begin
					want = decode_q.pop_front();
					if (instr_class !== want.instr_class)
						flag_mismatch("instr_class", 32'(instr_class), 32'(want.instr_class));
					if (variant !== want.variant)
						flag_mismatch("variant", 32'(variant), 32'(want.variant));
					if (dest_reg !== want.dest_reg)
						flag_mismatch("dest_reg", 32'(dest_reg), 32'(want.dest_reg));
					if (base_reg !== want.base_reg)
						flag_mismatch("base_reg", 32'(base_reg), 32'(want.base_reg));
					if (index_reg !== want.index_reg)
						flag_mismatch("index_reg", 32'(index_reg), 32'(want.index_reg));
					if (immediate !== want.immediate)
						flag_mismatch("immediate", 32'(immediate), 32'(want.immediate));
					if (condition !== want.condition)
						flag_mismatch("condition", 32'(condition), 32'(want.condition));
					if (reg_list !== want.reg_list)
						flag_mismatch("reg_list", 32'(reg_list), 32'(want.reg_list));
					if (extra_reg !== want.extra_reg)
						flag_mismatch("extra_reg", 32'(extra_reg), 32'(want.extra_reg));
					if (branch_offset !== want.branch_offset)
						flag_mismatch("branch_offset", 32'(branch_offset),
							32'(want.branch_offset));
					if (target !== want.target)
						flag_mismatch("target", target, want.target);
					if (decoded !== want.decoded)
						flag_mismatch("decoded", 32'(decoded), 32'(want.decoded));
				end
			end
			if (in_valid && in_ready) begin
				if (decode_halfword(halfword, address, fresh))
					decode_q.push_back(fresh);
			end
			awaiting <= decode_q.size();
		end
	end

endmodule

>>> verif/tb_thumb_instruction_decoder.sv
// Testbench top for the Thumb decoder: clock, reset, halfword stimulus, result drain, verdict.
`timescale 1ns / 100ps

module tb_thumb_instruction_decoder;
	import tid_pkg::*;

	// Random beats after the directed part; each long-branch pair adds one more
	localparam int RANDOM_ITEMS = 1600;
	// Receiver hold-offs long enough to back the decoder up into its input
	localparam int HOLD_CYCLES  = 300;
	localparam int HOLD_AT_1    = 400;
	localparam int HOLD_AT_2    = 1300;
	// Settle time after the last expected result: two-stage pipe plus margin
	localparam int DRAIN_CYCLES = 8;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [15:0] halfword;
	logic [31:0] address;
	logic        out_valid;
	logic        out_ready;
	logic [5:0]  instr_class;
	logic [3:0]  variant;
	logic [3:0]  dest_reg;
	logic [3:0]  base_reg;
	logic [3:0]  index_reg;
	logic [9:0]  immediate;
	logic [3:0]  condition;
	logic [7:0]  reg_list;
	logic        extra_reg;
	logic [22:0] branch_offset;
	logic [31:0] target;
	logic        decoded;
	int          mismatches;
	int          awaiting;

	// Burst flags: while set, that side adds no random gaps (the receiver's long hold-offs still apply)
	bit          sender_rush;
	bit          receiver_rush;
	logic [31:0] fetch_addr;

	thumb_instruction_decoder u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .halfword(halfword), .address(address),
		.out_valid(out_valid), .out_ready(out_ready),
		.instr_class(instr_class), .variant(variant), .dest_reg(dest_reg),
		.base_reg(base_reg), .index_reg(index_reg), .immediate(immediate),
		.condition(condition), .reg_list(reg_list), .extra_reg(extra_reg),
		.branch_offset(branch_offset), .target(target), .decoded(decoded)
	);

	thumb_decode_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .halfword(halfword), .address(address),
		.out_valid(out_valid), .out_ready(out_ready),
		.instr_class(instr_class), .variant(variant), .dest_reg(dest_reg),
		.base_reg(base_reg), .index_reg(index_reg), .immediate(immediate),
		.condition(condition), .reg_list(reg_list), .extra_reg(extra_reg),
		.branch_offset(branch_offset), .target(target), .decoded(decoded),
		.mismatches(mismatches), .awaiting(awaiting)
	);

	// 12 ns period
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Offer one input beat. Called at a falling edge, returns at the falling edge
	// after the beat is taken. With no gap, valid stays high and only the payload
	// moves on, so valid never sees two updates in one step.
	task automatic send_beat(input logic [15:0] hw, input logic [31:0] addr);
		int gap;
		gap = sender_rush ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		halfword <= hw;
		address  <= addr;
		do @(posedge clk); while (!(in_valid && in_ready));
		@(negedge clk);
	endtask

	// Hard stop in case the handshake hangs
	initial begin
		#6ms;
		$display("*** FAILED ***");
		$finish;
	end

	// Result side: random stalls per beat, bursts with none, and two long hold-offs
	// during which the sender keeps offering so the decoder fills and stalls in_ready.
	initial begin
		int gap;
		int beats;
		out_ready     = 1'b0;
		receiver_rush = 1'b0;
		beats         = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (beats % 64 == 0)
				receiver_rush = ($urandom_range(0, 3) == 0);
			if (beats == HOLD_AT_1 || beats == HOLD_AT_2) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			gap = receiver_rush ? 0 : $urandom_range(0, 4);
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			@(negedge clk);
			beats++;
		end
	end

	initial begin
		logic [15:0] word;
		int          kind;
		int          tail;
		bit          is_prefix;
		// Drive every input to a known value before reset lifts
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		halfword      = '0;
		address       = '0;
		sender_rush   = 1'b0;
		fetch_addr    = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: field extremes, one of each class, and the corner cases
		send_beat(16'h0000, 32'h0000_0000);   // lsl r0, r0, #0
		send_beat(16'h17FF, 32'hFFFF_FFFE);   // asr, imm 31, highest regs
		send_beat(16'h1800, 32'h1234_5678);   // add reg
		send_beat(16'h1BFF, 32'h8000_0000);   // sub reg
		send_beat(16'h1C07, 32'h0000_0002);   // add imm3 of 0 reads as mov low
		send_beat(16'h1DFF, 32'h0000_0004);   // add imm3
		send_beat(16'h1FFF, 32'h0000_0006);   // sub imm3
		send_beat(16'h20FF, 32'h0000_0008);   // mov imm8
		send_beat(16'h3FFF, 32'h0000_000A);   // sub imm8
		send_beat(16'h43FF, 32'h0000_000C);   // alu, opcode 15
		send_beat(16'h44FF, 32'h0000_000E);   // add hi, both r15
		send_beat(16'h46C0, 32'h0000_0010);   // mov r8, r8 is the nop
		send_beat(16'h46FF, 32'h0000_0012);   // mov hi
		send_beat(16'h4770, 32'h0000_0014);   // bx lr is a return
		send_beat(16'h47F8, 32'h0000_0016);   // blx register
		send_beat(16'h5FFF, 32'h0000_0018);   // ldrsh reg offset
		send_beat(16'h6FFF, 32'h0000_001A);   // ldr word imm, largest offset
		send_beat(16'h8FFF, 32'h0000_001C);   // ldrh imm
		send_beat(16'h9FFF, 32'h0000_001E);   // ldr sp-relative
		send_beat(16'h4FFF, 32'hFFFF_FFFE);   // ldr literal, target wraps
		send_beat(16'hB0FF, 32'h0000_0020);   // sub sp
		send_beat(16'hA7FF, 32'hFFFF_FFFC);   // adr, target wraps
		send_beat(16'hD080, 32'h0000_0000);   // beq, most negative offset, wraps
		send_beat(16'hDEFF, 32'h0000_0022);   // undefined space gives nothing decoded
		send_beat(16'hDFFF, 32'h0000_0024);   // swi space gives nothing decoded
		send_beat(16'hB27F, 32'h0000_0026);   // sxtb
		send_beat(16'hBDFF, 32'h0000_0028);   // pop with pc
		send_beat(16'hCFFF, 32'h0000_002A);   // ldmia
		send_beat(16'hE400, 32'h0000_0000);   // b, most negative offset
		send_beat(16'hF3FF, 32'h7FFF_FFFC);   // prefix, largest positive high part
		send_beat(16'hFFFF, 32'h7FFF_FFFE);   // bl completes it
		send_beat(16'hF400, 32'h0000_0002);   // prefix, most negative
		send_beat(16'hE801, 32'h0000_0004);   // blx, target aligned down
		send_beat(16'hF000, 32'h0000_0100);   // prefix followed by another prefix:
		send_beat(16'hF7FF, 32'h0000_0102);   // the second one completes a bl
		send_beat(16'hBE00, 32'h0000_0104);   // unmatched halfword

		// Random part: mostly class-shaped halfwords with random content, a share of
		// long-branch pairs, and raw noise. Addresses mostly run sequentially.
		fetch_addr = $urandom;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0)
				sender_rush = ($urandom_range(0, 3) == 0);
			kind      = $urandom_range(0, 11);
			is_prefix = 1'b0;
			case (kind)
				2: word = {4'($urandom_range(0, 4)), 12'($urandom)};
				3: word = {8'(8'h40 + $urandom_range(0, 7)), 8'($urandom)};
				4: word = {4'($urandom_range(5, 9)), 12'($urandom)};
				5: word = {4'($urandom_range(10, 12)), 12'($urandom)};
				6: word = {4'hB, 12'($urandom)};
				7: word = {4'hD, 12'($urandom)};
				8: word = {OP_UNCOND_B, 11'($urandom)};
				9, 10: begin
					word      = {3'b111, 2'($urandom_range(1, 3)), 11'($urandom)};
					is_prefix = 1'b1;
				end
				default: word = 16'($urandom);
			endcase
			// Jump now and then, sometimes to just below the wrap point
			if ($urandom_range(0, 15) == 0)
				fetch_addr = $urandom;
			else if ($urandom_range(0, 31) == 0)
				fetch_addr = 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
			else
				fetch_addr = fetch_addr + 32'd2;
			send_beat(word, fetch_addr);
			if (is_prefix) begin
				// Completion: a blx or bl suffix, another prefix, or anything at all
				tail = $urandom_range(0, 5);
				case (tail)
					0, 1: word = {5'b11101, 11'($urandom)};
					2, 3: word = {5'b11111, 11'($urandom)};
					4:    word = {3'b111, 2'($urandom_range(1, 3)), 11'($urandom)};
					default: word = 16'($urandom);
				endcase
				fetch_addr = fetch_addr + 32'd2;
				send_beat(word, fetch_addr);
			end
		end
		in_valid <= 1'b0;

		// Drain: wait out every expected result, then give stray beats time to show
		while (awaiting != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
